// ===== hw/rtl/brrm_pkg.sv =====
// brrm_pkg: shared constants, source codes and request structs for the
// banked ROM/RAM mapper. No dependencies.
package brrm_pkg;

    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 8;
    localparam int CFG_W       = 22;
    localparam int ROM_ADDR_W  = 21;
    localparam int ROM_OFF_W   = 14;
    localparam int ROM_LOW_W   = 5;
    localparam int RAM_SEL_W   = 2;
    localparam int RAM_OFF_W   = 13;
    localparam int RAM_ADDR_W  = RAM_SEL_W + RAM_OFF_W;
    localparam int RAM_DEPTH   = 1 << RAM_ADDR_W;
    localparam int BOOT_ADDR_W = 8;
    localparam int SRC_W       = 3;

    localparam logic [ADDR_W-1:0] ADDR_ENABLE_END = 16'h1FFF;
    localparam logic [ADDR_W-1:0] ADDR_ROM0_END   = 16'h3FFF;
    localparam logic [ADDR_W-1:0] ADDR_BANKLO_END = 16'h3FFF;
    localparam logic [ADDR_W-1:0] ADDR_BANKHI_END = 16'h5FFF;
    localparam logic [ADDR_W-1:0] ADDR_ROMX_END   = 16'h7FFF;
    localparam logic [ADDR_W-1:0] ADDR_BOOT_REG   = 16'hFF50;
    localparam logic [ADDR_W-1:0] ADDR_RAM_START  = 16'hA000;
    localparam logic [ADDR_W-1:0] ADDR_RAM_END    = 16'hBFFF;
    localparam logic [DATA_W-1:0] OPEN_BUS_DATA   = 8'hFF;

    typedef enum logic [SRC_W-1:0] {
        SRC_OPEN    = 3'd0,
        SRC_BOOT    = 3'd1,
        SRC_ROM     = 3'd2,
        SRC_RAM     = 3'd3,
        SRC_BOOTREG = 3'd4
    } t_source;

    typedef struct packed {
        logic                  we;
        logic                  re;
        logic [RAM_ADDR_W-1:0] addr;
        logic [DATA_W-1:0]     wdata;
    } t_ram_req;

    typedef struct packed {
        t_source                source;
        logic [DATA_W-1:0]      data;
        logic [ROM_ADDR_W-1:0]  rom_address;
        logic [BOOT_ADDR_W-1:0] boot_address;
    } t_result;

endpackage

// ===== hw/rtl/brrm_ram.sv =====
// brrm_ram: external RAM array with registered read and a zeroing sweep
// after reset. Depends on brrm_pkg.
module brrm_ram (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  brrm_pkg::t_ram_req                    i_req,
    output logic [brrm_pkg::DATA_W-1:0]           o_rdata,
    output logic                                  o_busy
);

    logic [brrm_pkg::DATA_W-1:0]     r_mem [brrm_pkg::RAM_DEPTH];
    logic [brrm_pkg::DATA_W-1:0]     r_rdata;
    logic [brrm_pkg::RAM_ADDR_W-1:0] r_clr_addr;
    logic                            r_clr_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {brrm_pkg::RAM_ADDR_W{1'b1}}) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clr_busy;

endmodule

// ===== hw/rtl/brrm_ctrl.sv =====
// brrm_ctrl: bank registers, ROM length register and bus address decode.
// Depends on brrm_pkg.
module brrm_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [brrm_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_accept,
    input  logic                              i_action,
    input  logic [brrm_pkg::ADDR_W-1:0]       i_address,
    input  logic [brrm_pkg::DATA_W-1:0]       i_write_data,
    output brrm_pkg::t_result                 o_result,
    output brrm_pkg::t_ram_req                o_ram_req
);

    logic [brrm_pkg::CFG_W-1:0]     r_rom_length;
    logic                           r_ram_enabled;
    logic [brrm_pkg::ROM_LOW_W-1:0] r_rom_bank_low;
    logic [brrm_pkg::RAM_SEL_W-1:0] r_ram_bank;
    logic                           r_banking_mode;
    logic                           r_boot_on;

    logic                              in_ram_win;
    logic [brrm_pkg::ROM_LOW_W-1:0]    bank_low;
    logic [brrm_pkg::RAM_SEL_W-1:0]    bank_hi;
    logic [brrm_pkg::ROM_ADDR_W-1:0]   rom_addr;
    logic                              rom_open;

    assign in_ram_win = (i_address >= brrm_pkg::ADDR_RAM_START)
                     && (i_address <= brrm_pkg::ADDR_RAM_END);
    assign bank_low = (r_rom_bank_low == '0) ? brrm_pkg::ROM_LOW_W'(1) : r_rom_bank_low;
    assign bank_hi  = r_banking_mode ? r_ram_bank : '0;

    always_comb begin
        if (i_address <= brrm_pkg::ADDR_ROM0_END) begin
            rom_addr = brrm_pkg::ROM_ADDR_W'(i_address);
        end else begin
            rom_addr = {bank_hi, bank_low, i_address[brrm_pkg::ROM_OFF_W-1:0]};
        end
    end

    assign rom_open = ({1'b0, rom_addr} >= r_rom_length);

    always_comb begin
        o_result = '{source: brrm_pkg::SRC_OPEN, data: brrm_pkg::OPEN_BUS_DATA,
                     rom_address: '0, boot_address: '0};
        if (i_address <= brrm_pkg::ADDR_ROMX_END) begin
            if (r_boot_on && i_address[brrm_pkg::ADDR_W-1:brrm_pkg::BOOT_ADDR_W] == '0) begin
                o_result.source       = brrm_pkg::SRC_BOOT;
                o_result.data         = '0;
                o_result.boot_address = i_address[brrm_pkg::BOOT_ADDR_W-1:0];
            end else if (!rom_open) begin
                o_result.source      = brrm_pkg::SRC_ROM;
                o_result.data        = '0;
                o_result.rom_address = rom_addr;
            end
        end else if (i_address == brrm_pkg::ADDR_BOOT_REG) begin
            o_result.source = brrm_pkg::SRC_BOOTREG;
            o_result.data   = brrm_pkg::DATA_W'(!r_boot_on);
        end else if (in_ram_win) begin
            o_result.source = brrm_pkg::SRC_RAM;
            o_result.data   = '0;
        end
    end

    assign o_ram_req.addr  = {r_ram_bank, i_address[brrm_pkg::RAM_OFF_W-1:0]};
    assign o_ram_req.wdata = i_write_data;
    assign o_ram_req.we    = i_accept && i_action && in_ram_win && r_ram_enabled;
    assign o_ram_req.re    = i_accept && !i_action && in_ram_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_length   <= '0;
            r_ram_enabled  <= 1'b0;
            r_rom_bank_low <= '0;
            r_ram_bank     <= '0;
            r_banking_mode <= 1'b0;
            r_boot_on      <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_rom_length <= i_cfg_data;
            end
            if (i_accept && i_action) begin
                if (i_address <= brrm_pkg::ADDR_ENABLE_END) begin
                    r_ram_enabled <= i_write_data[3] && i_write_data[1];
                end else if (i_address <= brrm_pkg::ADDR_BANKLO_END) begin
                    r_rom_bank_low <= i_write_data[brrm_pkg::ROM_LOW_W-1:0];
                end else if (i_address <= brrm_pkg::ADDR_BANKHI_END) begin
                    r_ram_bank <= i_write_data[brrm_pkg::RAM_SEL_W-1:0];
                end else if (i_address <= brrm_pkg::ADDR_ROMX_END) begin
                    r_banking_mode <= i_write_data[0];
                end else if (i_address == brrm_pkg::ADDR_BOOT_REG) begin
                    if (i_write_data != '0) begin
                        r_boot_on <= 1'b0;
                    end
                end
            end
        end
    end

endmodule

// ===== hw/rtl/banked_rom_ram_mapper.sv =====
// banked_rom_ram_mapper: one bus request per cycle; a read gives its result
// in the next cycle, a write gives none. Throughput is one request per
// cycle, but o_ready is low during the RAM sweep and, for reads, while a
// result waits in the output register. Synchronous active-low reset clears
// the bank registers, sets the boot overlay, then a zeroing sweep of
// the RAM holds o_ready low. Depends on brrm_pkg, brrm_ctrl and brrm_ram.
module banked_rom_ram_mapper (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [brrm_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_action,
    input  logic [brrm_pkg::ADDR_W-1:0]          i_address,
    input  logic [brrm_pkg::DATA_W-1:0]          i_write_data,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [brrm_pkg::DATA_W-1:0]          o_read_data,
    output logic [brrm_pkg::SRC_W-1:0]           o_source,
    output logic [brrm_pkg::ROM_ADDR_W-1:0]      o_rom_address,
    output logic [brrm_pkg::BOOT_ADDR_W-1:0]     o_boot_address
);

    brrm_pkg::t_result  dec_result;
    brrm_pkg::t_ram_req ram_req;
    brrm_pkg::t_result  r_result;
    logic               r_out_valid;
    logic [brrm_pkg::DATA_W-1:0] ram_rdata;
    logic               ram_busy;
    logic               in_accept;

    assign o_ready   = !ram_busy && (!r_out_valid || i_ready || i_action);
    assign in_accept = i_valid && o_ready;

    brrm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (in_accept),
        .i_action     (i_action),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .o_result     (dec_result),
        .o_ram_req    (ram_req)
    );

    brrm_ram u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ram_req),
        .o_rdata (ram_rdata),
        .o_busy  (ram_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && !i_action) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && !i_action) begin
            r_result <= dec_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_source       = r_result.source;
    assign o_read_data    = (r_result.source == brrm_pkg::SRC_RAM) ? ram_rdata : r_result.data;
    assign o_rom_address  = r_result.rom_address;
    assign o_boot_address = r_result.boot_address;

`ifndef NO_ASSERTIONS
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_busy |-> !o_ready)
        else $error("request accepted during RAM sweep");
    a_no_result_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_busy |-> !r_out_valid)
        else $error("result pending during RAM sweep");
    a_read_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && !i_action |=> r_out_valid)
        else $error("accepted read produced no result");
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_action && (!r_out_valid || i_ready) |=> !r_out_valid)
        else $error("write produced a result");
    a_rom_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.source != brrm_pkg::SRC_ROM |-> r_result.rom_address == '0)
        else $error("ROM address set for non-ROM source");
`endif

endmodule
